// ===== sv/assert_macros.svh =====
// Shared assertion macros; the user module must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Combinational check, sampled on every rising clock edge out of reset.
`define BBA_ASSERT_NOW(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define BBA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BBA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// Types, codes and helpers for the bitmap block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

    localparam int MAX_WORDS = 512;   // 32768 block indexes / 64 bits per word

    localparam logic OP_FIND = 1'b0;
    localparam logic OP_RSV  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NONE  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic REG_BLOCKS = 1'b0;   // register select, paddr[2]

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_BYTE,
        S_RSV_RD,
        S_RSV_WR,
        S_POST
    } state_t;

    // position of the lowest clear bit in a byte (byte must not be all ones)
    function automatic logic [2:0] lowest_zero8(input logic [7:0] b);
        logic [2:0] pos;
        pos = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (!b[i])
            begin
                pos = 3'(i);
            end
        end
        return pos;
    endfunction

endpackage

`default_nettype wire

// ===== sv/bitmap_block_allocator_core.sv =====
// Find: accept, then bitmap words are read in order until a word with a clear
//   bit, then up to 8 byte-shift steps, then output; one word RAM port paces it.
// Reserve: accept, read, modify-write, output; a reserve out of range
//   and a find with no active bitmap block go from accept to output. One item at a time.
// Reset: bitmap RAM is swept to zero, one word per cycle, over min(BITMAP_BLOCKS *
//   BLOCK_BYTES / 8, 512) words (512 at defaults); no request taken meanwhile.
// ----------------------------------------------------------------------------
// bitmap_block_allocator_core
// First-fit free-block bitmap: find lowest clear bit, or mark a block used.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_block_allocator_core
    import bba_pkg::*;
#(
    parameter int BLOCK_BYTES   = 512,
    parameter int BITMAP_BLOCKS = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // request
    input  wire logic        req_valid,
    output logic             req_ready,
    input  wire logic        op,
    input  wire logic [14:0] blk_num,
    // response
    output logic             rsp_valid,
    input  wire logic        rsp_ready,
    output logic      [14:0] index,
    output logic      [1:0]  status
);

    localparam int MAP_WORDS = (BITMAP_BLOCKS * BLOCK_BYTES) / 8;
    localparam int DEPTH     = (MAP_WORDS > MAX_WORDS) ? MAX_WORDS : MAP_WORDS;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LIM_W     = $clog2(DEPTH + 1);

    state_t            state_reg, state_next;
    logic [3:0]        blocks_reg;
    logic [AW-1:0]     clr_reg, clr_next;
    logic [LIM_W-1:0]  issue_reg, issue_next;
    logic [AW-1:0]     chk_reg, chk_next;
    logic              pend_reg, pend_next;
    logic [63:0]       work_reg, work_next;
    logic [2:0]        byte_reg, byte_next;
    logic [14:0]       bidx_reg, bidx_next;
    logic [14:0]       res_index_reg, res_index_next;
    logic [1:0]        res_status_reg, res_status_next;
    logic              out_valid_reg, out_valid_next;
    logic [14:0]       index_reg, index_next;
    logic [1:0]        status_reg, status_next;
    logic [63:0]       rdata_reg;

    logic [63:0]       mem [DEPTH];
    logic              rd_en, wr_en;
    logic [AW-1:0]     rd_addr, wr_addr;
    logic [63:0]       wr_data;

    logic [3:0]        blocks_sat;
    logic [31:0]       lim_prod;
    logic [LIM_W-1:0]  words_lim;
    logic              in_range;
    logic              chk_last;
    logic              req_fire, out_free, cfg_wr;

    // active word count, capped at the 15-bit index range
    always_comb
    begin
        blocks_sat = (32'(blocks_reg) > 32'(BITMAP_BLOCKS)) ? 4'(BITMAP_BLOCKS) : blocks_reg;
        lim_prod   = (32'(blocks_sat) * 32'(BLOCK_BYTES)) >> 3;
        words_lim  = (lim_prod > 32'(DEPTH)) ? LIM_W'(DEPTH) : LIM_W'(lim_prod);
    end

    assign in_range  = 10'(blk_num[14:6]) < 10'(words_lim);
    assign chk_last  = (10'(chk_reg) + 10'd1) == 10'(words_lim);
    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign out_free  = !out_valid_reg || rsp_ready;

    // APB
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_BLOCKS);
    assign prdata = (paddr[2] == REG_BLOCKS) ? {28'd0, blocks_reg} : 32'd0;

    assign rsp_valid = out_valid_reg;
    assign index     = index_reg;
    assign status    = status_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_fire)
                begin
                    if (op == OP_FIND)
                    begin
                        state_next = (words_lim == '0) ? S_POST : S_SCAN;
                    end
                    else
                    begin
                        state_next = in_range ? S_RSV_RD : S_POST;
                    end
                end
            end
            S_SCAN:
            begin
                if (pend_reg && (rdata_reg != '1))
                begin
                    state_next = S_BYTE;
                end
                else if (pend_reg && chk_last)
                begin
                    state_next = S_POST;
                end
            end
            S_BYTE:
            begin
                if (work_reg[7:0] != 8'hFF)
                begin
                    state_next = S_POST;
                end
            end
            S_RSV_RD: state_next = S_RSV_WR;
            S_RSV_WR: state_next = S_POST;
            S_POST:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb
    begin
        clr_next        = clr_reg;
        issue_next      = issue_reg;
        chk_next        = chk_reg;
        pend_next       = pend_reg;
        work_next       = work_reg;
        byte_next       = byte_reg;
        bidx_next       = bidx_reg;
        res_index_next  = res_index_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !rsp_ready;
        index_next      = index_reg;
        status_next     = status_reg;
        rd_en           = 1'b0;
        rd_addr         = issue_reg[AW-1:0];
        wr_en           = 1'b0;
        wr_addr         = clr_reg;
        wr_data         = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en    = 1'b1;
                clr_next = clr_reg + AW'(1);
            end
            S_IDLE:
            begin
                if (req_fire)
                begin
                    bidx_next  = blk_num;
                    issue_next = '0;
                    pend_next  = 1'b0;
                    if (op == OP_FIND)
                    begin
                        res_index_next  = '0;
                        res_status_next = ST_NONE;
                    end
                    else
                    begin
                        res_index_next  = blk_num;
                        res_status_next = ST_RANGE;
                    end
                end
            end
            S_SCAN:
            begin
                if (pend_reg && (rdata_reg != '1))
                begin
                    work_next = rdata_reg;
                    byte_next = '0;
                end
                else if (pend_reg && chk_last)
                begin
                    res_index_next  = '0;
                    res_status_next = ST_NONE;
                end
                else if (issue_reg < words_lim)
                begin
                    // keep one read in flight: issue word n while checking n-1
                    rd_en      = 1'b1;
                    rd_addr    = issue_reg[AW-1:0];
                    chk_next   = issue_reg[AW-1:0];
                    issue_next = issue_reg + LIM_W'(1);
                    pend_next  = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            S_BYTE:
            begin
                if (work_reg[7:0] != 8'hFF)
                begin
                    res_index_next  = 15'({chk_reg, byte_reg, lowest_zero8(work_reg[7:0])});
                    res_status_next = ST_OK;
                end
                else
                begin
                    work_next = work_reg >> 8;
                    byte_next = byte_reg + 3'd1;
                end
            end
            S_RSV_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = bidx_reg[6 +: AW];
            end
            S_RSV_WR:
            begin
                wr_en           = 1'b1;
                wr_addr         = bidx_reg[6 +: AW];
                wr_data         = rdata_reg | (64'd1 << bidx_reg[5:0]);
                res_index_next  = bidx_reg;
                res_status_next = ST_OK;
            end
            S_POST:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    index_next     = res_index_reg;
                    status_next    = res_status_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            blocks_reg    <= 4'd8;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr)
            begin
                blocks_reg <= pwdata[3:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        issue_reg      <= issue_next;
        chk_reg        <= chk_next;
        work_reg       <= work_next;
        byte_reg       <= byte_next;
        bidx_reg       <= bidx_next;
        res_index_reg  <= res_index_next;
        res_status_reg <= res_status_next;
        index_reg      <= index_next;
        status_reg     <= status_next;
    end

    // bitmap RAM: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/bba_checker.sv =====
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks for the bitmap block allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bba_checker
    import bba_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        pready,
    input wire logic        req_valid,
    input wire logic        req_ready,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic [14:0] index,
    input wire logic [1:0]  status
);

    `BBA_ASSERT_NOW(a_pready_high, pready == 1'b1, "pready dropped")

    `BBA_ASSERT_IMP(a_status_code, rsp_valid, status != 2'd3, "undefined status code")

    `BBA_ASSERT_IMP(a_none_zero, rsp_valid && (status == ST_NONE), index == 15'd0,
        "no-free response with nonzero index")

    `BBA_ASSERT_NXT(a_busy_after_req, req_valid && req_ready, !req_ready,
        "request taken while previous transaction still in work")

    `BBA_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready,
        rsp_valid && $stable(index) && $stable(status), "stalled response changed")

endmodule

bind bitmap_block_allocator_core bba_checker u_bba_checker (.*);

`default_nettype wire

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the first-fit bitmap block allocator. A directed
// table hits the range edges, the saturating and zero size settings and the
// echo rules, then random find/reserve traffic packs the low end of the bitmap
// so that finds scan across several words. Every reply is compared against an
// internal bitmap model, or against the reply given in the table for typed rows.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
    import bba_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BLK_BYTES  = 512;
    localparam int MAP_BLOCKS = 8;
    localparam int MAP_WORDS  = MAP_BLOCKS * BLK_BYTES / 8;
    localparam int IDX_SPAN   = 32768;
    localparam int TAIL_WAIT  = 600;    // longest find scan plus margin
    localparam int LONG_HOLD  = 300;

    localparam logic [2:0] BLOCKS_ADDR = {REG_BLOCKS, 2'b00};

    typedef struct packed {
        logic [14:0] index;
        logic [1:0]  status;
    } reply_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic        opv;
        logic [14:0] arg;       // block index, or bitmap block count for ROW_CFG
        bit          typed;
        reply_t      reply;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    wire  [31:0] prdata;
    wire         pready;
    logic        req_valid = 1'b0;
    wire         req_ready;
    logic        op = OP_FIND;
    logic [14:0] blk_num = '0;
    wire         rsp_valid;
    logic        rsp_ready = 1'b0;
    wire  [14:0] index;
    wire  [1:0]  status;

    // model state
    bit [63:0]   shadow_map [MAP_WORDS];
    bit [3:0]    shadow_blocks = 4'd8;
    reply_t      awaited[$];

    int          mismatches = 0;
    int          n_find = 0;
    int          n_rsv = 0;
    int          n_cfg = 0;
    int          n_ok = 0;
    int          n_none = 0;
    int          n_range = 0;
    bit          no_idle = 1'b0;
    bit          rx_hold_req = 1'b0;
    logic [14:0] fill_ptr = '0;

    stim_row_t dir_rows [25] = '{
        '{ROW_ITEM, OP_FIND, 15'd0,     1'b1, '{15'd0,     ST_OK}},
        '{ROW_ITEM, OP_RSV,  15'd0,     1'b1, '{15'd0,     ST_OK}},
        '{ROW_ITEM, OP_RSV,  15'd32767, 1'b1, '{15'd32767, ST_OK}},
        '{ROW_ITEM, OP_FIND, 15'd32767, 1'b1, '{15'd1,     ST_OK}},
        '{ROW_ITEM, OP_RSV,  15'd1,     1'b1, '{15'd1,     ST_OK}},
        '{ROW_ITEM, OP_RSV,  15'd1,     1'b1, '{15'd1,     ST_OK}},
        '{ROW_ITEM, OP_RSV,  15'd7,     1'b0, '{15'd0,     ST_OK}},
        '{ROW_ITEM, OP_RSV,  15'd8,     1'b0, '{15'd0,     ST_OK}},
        '{ROW_ITEM, OP_FIND, 15'd0,     1'b0, '{15'd0,     ST_OK}},
        '{ROW_ITEM, OP_RSV,  15'd63,    1'b0, '{15'd0,     ST_OK}},
        '{ROW_ITEM, OP_RSV,  15'd64,    1'b0, '{15'd0,     ST_OK}},
        '{ROW_CFG,  OP_FIND, 15'd1,     1'b0, '{15'd0,     ST_OK}},
        '{ROW_ITEM, OP_RSV,  15'd4095,  1'b1, '{15'd4095,  ST_OK}},
        '{ROW_ITEM, OP_RSV,  15'd4096,  1'b1, '{15'd4096,  ST_RANGE}},
        '{ROW_ITEM, OP_RSV,  15'd32767, 1'b1, '{15'd32767, ST_RANGE}},
        '{ROW_CFG,  OP_FIND, 15'd0,     1'b0, '{15'd0,     ST_OK}},
        '{ROW_ITEM, OP_FIND, 15'd0,     1'b1, '{15'd0,     ST_NONE}},
        '{ROW_ITEM, OP_RSV,  15'd0,     1'b1, '{15'd0,     ST_RANGE}},
        '{ROW_ITEM, OP_RSV,  15'd21845, 1'b1, '{15'd21845, ST_RANGE}},
        '{ROW_CFG,  OP_FIND, 15'd15,    1'b0, '{15'd0,     ST_OK}},
        '{ROW_ITEM, OP_RSV,  15'd10922, 1'b0, '{15'd0,     ST_OK}},
        '{ROW_ITEM, OP_FIND, 15'd32767, 1'b0, '{15'd0,     ST_OK}},
        '{ROW_CFG,  OP_FIND, 15'd9,     1'b0, '{15'd0,     ST_OK}},
        '{ROW_ITEM, OP_RSV,  15'd16384, 1'b0, '{15'd0,     ST_OK}},
        '{ROW_CFG,  OP_FIND, 15'd8,     1'b0, '{15'd0,     ST_OK}}
    };

    bitmap_block_allocator_core #(
        .BLOCK_BYTES   (BLK_BYTES),
        .BITMAP_BLOCKS (MAP_BLOCKS)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .op          (op),
        .blk_num     (blk_num),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .index       (index),
        .status      (status)
    );

    always #2 clk = ~clk;

    // number of blocks covered by the active bitmap blocks
    function automatic int active_limit();
        int nblk;
        int bits;
        nblk = (shadow_blocks > MAP_BLOCKS) ? MAP_BLOCKS : int'(shadow_blocks);
        bits = nblk * BLK_BYTES * 8;
        if (bits > IDX_SPAN)
        begin
            bits = IDX_SPAN;
        end
        return bits;
    endfunction

    function automatic reply_t predict_alloc(logic opv, logic [14:0] idx);
        reply_t r;
        int     lim;
        int     b;
        lim = active_limit();
        if (opv == OP_FIND)
        begin
            for (int w = 0; w < lim / 64; w++)
            begin
                if (shadow_map[w] != '1)
                begin
                    b = 0;
                    while (shadow_map[w][b])
                    begin
                        b++;
                    end
                    r.index  = 15'(w * 64 + b);
                    r.status = ST_OK;
                    return r;
                end
            end
            r.index  = '0;
            r.status = ST_NONE;
            return r;
        end
        r.index = idx;
        if (int'(idx) < lim)
        begin
            shadow_map[idx / 64][idx % 64] = 1'b1;
            r.status = ST_OK;
        end
        else
        begin
            r.status = ST_RANGE;
        end
        return r;
    endfunction

    function automatic int draw_gap();
        return no_idle ? 0 : int'($urandom_range(0, 6));
    endfunction

    task automatic report_mismatch(string what);
        $display("ERROR @%0t: %s", $time, what);
        mismatches++;
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_item(logic opv, logic [14:0] idx, bit typed, reply_t typed_reply);
        int     gap;
        reply_t r;
        gap = draw_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        op        <= opv;
        blk_num   <= idx;
        do @(posedge clk); while (req_ready !== 1'b1);
        r = predict_alloc(opv, idx);
        if (typed)
        begin
            r = typed_reply;
        end
        awaited.push_back(r);
        if (opv == OP_FIND)
        begin
            n_find++;
        end
        else
        begin
            n_rsv++;
        end
        case (r.status)
            ST_OK:   n_ok++;
            ST_NONE: n_none++;
            default: n_range++;
        endcase
        @(negedge clk);
    endtask

    // stop offering and wait until every reply is in
    task automatic drain_replies();
        req_valid <= 1'b0;
        do @(negedge clk); while (awaited.size() != 0);
    endtask

    task automatic write_blocks(logic [3:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= BLOCKS_ADDR;
        pwdata  <= {28'($urandom), val};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        shadow_blocks = pwdata[3:0];
        n_cfg++;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic rand_item(int find_pct, int seq_pct, int max_step);
        int r;
        r = $urandom_range(0, 99);
        if (r < find_pct)
        begin
            send_item(OP_FIND, 15'($urandom), 1'b0, '0);
        end
        else if (r < find_pct + seq_pct)
        begin
            send_item(OP_RSV, fill_ptr, 1'b0, '0);
            fill_ptr += 15'($urandom_range(1, max_step));
        end
        else if ($urandom_range(0, 1) == 1)
        begin
            send_item(OP_RSV, 15'($urandom), 1'b0, '0);
        end
        else
        begin
            // straddle the edge of the active range
            send_item(OP_RSV, 15'(active_limit() + int'($urandom_range(0, 3)) - 2),
                      1'b0, '0);
        end
    endtask

    task automatic rand_phase(logic [3:0] blocks, int count, int find_pct, int seq_pct,
                              int max_step);
        drain_replies();
        write_blocks(blocks);
        repeat (count) rand_item(find_pct, seq_pct, max_step);
    endtask

    // response side
    initial
    begin
        int     stall;
        reply_t e;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = draw_gap();
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                stall = LONG_HOLD;
            end
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (rsp_valid !== 1'b1);
            if (awaited.size() == 0)
            begin
                report_mismatch($sformatf("reply with nothing outstanding: index=%0d status=%0d",
                                          index, status));
            end
            else
            begin
                e = awaited.pop_front();
                if (index !== e.index)
                begin
                    report_mismatch($sformatf("index %0d, expected %0d", index, e.index));
                end
                if (status !== e.status)
                begin
                    report_mismatch($sformatf("status %0d, expected %0d (index %0d)",
                                              status, e.status, e.index));
                end
            end
            @(negedge clk);
        end
    end

    // request side
    initial
    begin
        int n;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
            begin
                drain_replies();
                write_blocks(dir_rows[i].arg[3:0]);
            end
            else
            begin
                send_item(dir_rows[i].opv, dir_rows[i].arg, dir_rows[i].typed,
                          dir_rows[i].reply);
            end
        end

        rand_phase(4'd8, 150, 30, 50, 3);

        // pack the low end of the first bitmap block
        drain_replies();
        write_blocks(4'd1);
        fill_ptr = '0;
        n = 0;
        while (fill_ptr < 15'd600)
        begin
            if (n == 150)
            begin
                rx_hold_req = 1'b1;
            end
            if (n == 500)
            begin
                drain_replies();
            end
            no_idle = (n >= 250 && n < 400);
            rand_item(8, 85, 1);
            n++;
        end
        no_idle = 1'b0;
        repeat (40) rand_item(70, 0, 1);

        // two active blocks behind the packed low end: multi-word scans
        drain_replies();
        write_blocks(4'd2);
        no_idle = 1'b1;
        repeat (100) rand_item(30, 60, 2);
        no_idle = 1'b0;
        repeat (100) rand_item(30, 60, 2);

        rand_phase(4'd15, 150, 30, 40, 3);
        rand_phase(4'd0, 40, 40, 30, 3);
        rand_phase(4'd3, 150, 30, 50, 3);
        rand_phase(4'd8, 200, 30, 50, 3);

        drain_replies();
        repeat (TAIL_WAIT) @(negedge clk);

        $display("Covered %0d finds and %0d reserves across %0d bitmap size writes",
                 n_find, n_rsv, n_cfg);
        $display("Replies: %0d ok, %0d no free block, %0d out of range; %0d mismatches",
                 n_ok, n_none, n_range, mismatches);
        if (mismatches == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial
    begin
        #60ms;
        $display("Timeout: %0d replies still outstanding", awaited.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

// ===== bitmap_block_allocator_core.f =====
+incdir+sv
sv/bba_pkg.sv
sv/bitmap_block_allocator_core.sv
sv/bba_checker.sv
verif/testbench.sv
